>>> hw/rtl/u8esc_pkg.sv
`timescale 1ns / 1ps

package u8esc_pkg;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_COPY,
    OP_REPL
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef logic [3:0][7:0] byte4_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] len;
  } dec_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic head_none;
    logic step_last;
    logic out_free;
  } stat_t;

  localparam logic [7:0]  REPL_B0      = 8'hEF;
  localparam logic [7:0]  REPL_B1      = 8'hBF;
  localparam logic [7:0]  REPL_B2      = 8'hBD;
  localparam logic [2:0]  REPL_LEN     = 3'd3;
  localparam logic [2:0]  BUF_DEPTH    = 3'd4;
  localparam logic [20:0] CP_LIMIT     = 21'h110000;
  localparam logic [9:0]  SURR_HI      = 10'h01B;
  localparam logic [20:0] NONCHAR_LO   = 21'h00FDD0;
  localparam logic [20:0] NONCHAR_HI   = 21'h00FDEF;
  localparam logic [20:0] MIN_2B       = 21'h000080;
  localparam logic [20:0] MIN_3B       = 21'h000800;
  localparam logic [20:0] MIN_4B       = 21'h010000;

  function automatic logic [2:0] lead_len(logic [7:0] c);
    logic [2:0] l;
    if (!c[7])                  l = 3'd1;
    else if (c[7:5] == 3'b110)  l = 3'd2;
    else if (c[7:4] == 4'b1110) l = 3'd3;
    else if (c[7:3] == 5'b11110) l = 3'd4;
    else                        l = 3'd0;
    return l;
  endfunction

  // Resolve the sequence at the head of the buffer.
  function automatic dec_t decide(byte4_t b, logic [2:0] cnt, logic fin);
    dec_t        d;
    logic [2:0]  len;
    logic [2:0]  avail;
    logic        broken;
    logic [20:0] v;
    logic [20:0] minv;
    logic        ok;
    d.op   = OP_NONE;
    d.len  = 3'd0;
    len    = lead_len(b[0]);
    avail  = (cnt < len) ? cnt : len;
    broken = 1'b0;
    for (int i = 1; i < 4; i++) begin
      if ((3'(i) < avail) && (b[i][7:6] != 2'b10)) broken = 1'b1;
    end
    case (len)
      3'd2: begin
        v    = {10'd0, b[0][4:0], b[1][5:0]};
        minv = MIN_2B;
      end
      3'd3: begin
        v    = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
        minv = MIN_3B;
      end
      default: begin
        v    = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
        minv = MIN_4B;
      end
    endcase
    ok = (v >= minv) && (v < CP_LIMIT) && (v[20:11] != SURR_HI)
         && !((v >= NONCHAR_LO) && (v <= NONCHAR_HI)) && (v[15:1] != 15'h7FFF);
    if (cnt == 3'd0) begin
      d.op = OP_NONE;
    end else if (len == 3'd1) begin
      d.op  = OP_COPY;
      d.len = 3'd1;
    end else if (len == 3'd0 || broken) begin
      d.op  = OP_REPL;
      d.len = REPL_LEN;
    end else if (cnt >= len) begin
      if (ok) begin
        d.op  = OP_COPY;
        d.len = len;
      end else begin
        d.op  = OP_REPL;
        d.len = REPL_LEN;
      end
    end else if (fin) begin
      d.op  = OP_REPL;
      d.len = REPL_LEN;
    end
    return d;
  endfunction

endpackage

>>> hw/rtl/utf8_invalid_byte_escaper.sv
`timescale 1ns / 1ps
// UTF-8 escaper: copies a byte string, replacing the lead byte of every
// malformed or unacceptable sequence with EF BF BD and rescanning the bytes
// after it.
// Input channel: in_tdata carries one string byte, in_tlast marks the last
// byte of the string. A zero byte acts as the terminator and is not copied.
// Output channel: out_tdata carries one escaped byte, out_tlast marks the last
// byte caused by an input item, out_tuser marks the last byte of the string.
// An item is loaded, then each step registers one result byte (0 to 12 in all),
// one step per cycle while the output register is free; an item that gives no
// result (a byte held for a longer sequence) still enters the run state.
// One item is worked on at a time; the next is taken once the controller
// returns to idle. A single output register holds the latest result; while it
// waits on a stalled receiver the stepping stops until the register frees up,
// and in_tready stays low meanwhile.
// Reset empties the held-byte buffer and clears the output register's valid flag.
module utf8_invalid_byte_escaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] string_done
);

  u8esc_pkg::cmd_t  cmd;
  u8esc_pkg::stat_t stat;

  u8esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  u8esc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.step))
    else $error("load and step together");

  a_step_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> stat.out_free)
    else $error("step with output register busy");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("string end without item end");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

endmodule

>>> hw/rtl/u8esc_ctrl.sv
`timescale 1ns / 1ps

module u8esc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  u8esc_pkg::stat_t  stat,
  output u8esc_pkg::cmd_t   cmd
);

  u8esc_pkg::state_t state_r;
  u8esc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= u8esc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      u8esc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = u8esc_pkg::ST_RUN;
        end
      end
      u8esc_pkg::ST_RUN: begin
        if (stat.head_none) begin
          state_nxt = u8esc_pkg::ST_IDLE;
        end else if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.step_last) state_nxt = u8esc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = u8esc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/u8esc_dp.sv
`timescale 1ns / 1ps

module u8esc_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  u8esc_pkg::cmd_t   cmd,
  output u8esc_pkg::stat_t  stat,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);

  u8esc_pkg::byte4_t buf_r, buf_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              fin_r, fin_nxt;
  u8esc_pkg::op_t    op_r, op_nxt;
  logic [2:0]        rem_r, rem_nxt;
  logic              oval_r, oval_nxt;
  logic [7:0]        obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;
  logic              odone_r, odone_nxt;

  u8esc_pkg::dec_t   hd, nx;
  u8esc_pkg::byte4_t shifted;
  u8esc_pkg::op_t    cur_op;
  logic [2:0]        cur_rem;
  logic              active, act_last, drop;
  logic [7:0]        emit_byte;

  always_comb begin
    active   = (rem_r != 3'd0);
    hd       = u8esc_pkg::decide(buf_r, cnt_r, fin_r);
    shifted  = {buf_r[3], buf_r[3], buf_r[2], buf_r[1]};
    nx       = u8esc_pkg::decide(shifted, 3'(cnt_r - 3'd1), fin_r);
    cur_op   = active ? op_r : hd.op;
    cur_rem  = active ? rem_r : hd.len;
    act_last = (cur_rem == 3'd1);
    drop     = (cur_op == u8esc_pkg::OP_COPY) || act_last;
    if (cur_op == u8esc_pkg::OP_REPL) begin
      case (cur_rem)
        3'd3:    emit_byte = u8esc_pkg::REPL_B0;
        3'd2:    emit_byte = u8esc_pkg::REPL_B1;
        default: emit_byte = u8esc_pkg::REPL_B2;
      endcase
    end else begin
      emit_byte = buf_r[0];
    end
    stat.head_none = !active && (hd.op == u8esc_pkg::OP_NONE);
    stat.step_last = act_last && (nx.op == u8esc_pkg::OP_NONE);
    stat.out_free  = !oval_r || out_tready;
  end

  always_comb begin
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    op_nxt    = op_r;
    rem_nxt   = rem_r;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    odone_nxt = odone_r;
    oval_nxt  = oval_r && !out_tready;
    if (cmd.load) begin
      fin_nxt = in_tlast || (in_tdata == 8'd0);
      if ((in_tdata != 8'd0) && (cnt_r < u8esc_pkg::BUF_DEPTH)) begin
        buf_nxt[cnt_r[1:0]] = in_tdata;
        cnt_nxt             = 3'(cnt_r + 3'd1);
      end
    end else if (cmd.step) begin
      op_nxt    = cur_op;
      rem_nxt   = 3'(cur_rem - 3'd1);
      oval_nxt  = 1'b1;
      obyte_nxt = emit_byte;
      olast_nxt = stat.step_last;
      odone_nxt = stat.step_last && fin_r;
      if (drop) begin
        buf_nxt = shifted;
        cnt_nxt = 3'(cnt_r - 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 3'd0;
      rem_r  <= 3'd0;
      oval_r <= 1'b0;
      op_r   <= u8esc_pkg::OP_NONE;
      fin_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      oval_r <= oval_nxt;
      op_r   <= op_nxt;
      fin_r  <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r   <= buf_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = odone_r;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT = 400000;
  localparam int RAND_ITEMS = 120;
  localparam int TAIL_CYCLES = 32;
  localparam logic [23:0] REPL_SEQ = {u8esc_pkg::REPL_B2, u8esc_pkg::REPL_B1,
                                      u8esc_pkg::REPL_B0};

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       str_end;
  } esc_out_t;

  // n_typed == 0: expectation comes from the predictor
  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic [1:0]  n_typed;
    logic [23:0] typed;
  } stim_row_t;

  localparam stim_row_t DIR_TAB [26] = '{
    '{8'h01, 1'b0, 2'd1, 24'h000001},
    '{8'h7F, 1'b1, 2'd1, 24'h00007F},
    '{8'h80, 1'b0, 2'd3, REPL_SEQ},      // stray continuation
    '{8'hFF, 1'b0, 2'd3, REPL_SEQ},
    '{8'hF8, 1'b0, 2'd3, REPL_SEQ},      // 5-byte lead
    '{8'hC2, 1'b0, 2'd0, 24'h0},
    '{8'hA9, 1'b1, 2'd0, 24'h0},
    '{8'hC0, 1'b0, 2'd0, 24'h0},         // overlong
    '{8'h80, 1'b1, 2'd0, 24'h0},
    '{8'hED, 1'b0, 2'd0, 24'h0},         // surrogate
    '{8'hA0, 1'b0, 2'd0, 24'h0},
    '{8'h80, 1'b0, 2'd0, 24'h0},
    '{8'hEF, 1'b0, 2'd0, 24'h0},         // noncharacter FFFF
    '{8'hBF, 1'b0, 2'd0, 24'h0},
    '{8'hBF, 1'b1, 2'd0, 24'h0},
    '{8'hF4, 1'b0, 2'd0, 24'h0},         // above 10FFFF
    '{8'h90, 1'b0, 2'd0, 24'h0},
    '{8'h80, 1'b0, 2'd0, 24'h0},
    '{8'h80, 1'b1, 2'd0, 24'h0},
    '{8'hF0, 1'b0, 2'd0, 24'h0},         // early break, then end of string
    '{8'h9F, 1'b0, 2'd0, 24'h0},
    '{8'h41, 1'b1, 2'd0, 24'h0},
    '{8'hE2, 1'b0, 2'd0, 24'h0},         // zero byte flushes held bytes
    '{8'h82, 1'b0, 2'd0, 24'h0},
    '{8'h00, 1'b0, 2'd0, 24'h0},
    '{8'h00, 1'b0, 2'd0, 24'h0}          // zero byte, nothing held
  };

  localparam logic [20:0] CORNER_CP [19] = '{
    21'h000080, 21'h0007FF, 21'h000800, 21'h00D7FF, 21'h00D800,
    21'h00DFFF, 21'h00E000, 21'h00FDCF, 21'h00FDD0, 21'h00FDEF,
    21'h00FDF0, 21'h00FFFD, 21'h00FFFE, 21'h00FFFF, 21'h010000,
    21'h01FFFE, 21'h10FFFF, 21'h110000, 21'h1FFFFF
  };

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  logic [7:0] held_q[$];
  esc_out_t   step_q[$];
  esc_out_t   exp_q[$];
  int         n_err = 0;
  int         cyc = 0;
  logic       tx_burst = 1'b0;
  logic       rx_burst = 1'b0;

  utf8_invalid_byte_escaper i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Escaped bytes caused by one input item; updates the held-byte buffer.
  function automatic void escape_step(logic [7:0] b, logic last_in);
    logic             fin;
    logic [2:0]       n;
    int               avail;
    logic             broken;
    logic [20:0]      v;
    logic [20:0]      minv;
    u8esc_pkg::op_t   op;
    fin = last_in || (b == 8'h00);
    step_q.delete();
    if (b != 8'h00 && held_q.size() < 4) held_q.push_back(b);
    while (held_q.size() > 0) begin
      if (!held_q[0][7]) n = 3'd1;
      else if (held_q[0][7:5] == 3'b110) n = 3'd2;
      else if (held_q[0][7:4] == 4'b1110) n = 3'd3;
      else if (held_q[0][7:3] == 5'b11110) n = 3'd4;
      else n = 3'd0;
      op = u8esc_pkg::OP_NONE;
      if (n == 3'd1) begin
        op = u8esc_pkg::OP_COPY;
      end else if (n == 3'd0) begin
        op = u8esc_pkg::OP_REPL;
      end else begin
        avail = (held_q.size() < int'(n)) ? held_q.size() : int'(n);
        broken = 1'b0;
        for (int i = 1; i < avail; i++) begin
          if (held_q[i][7:6] != 2'b10) broken = 1'b1;
        end
        if (broken) begin
          op = u8esc_pkg::OP_REPL;
        end else if (held_q.size() >= int'(n)) begin
          v = 21'(held_q[0] & (8'h7F >> n));
          for (int i = 1; i < int'(n); i++) v = (v << 6) | 21'(held_q[i][5:0]);
          minv = (n == 3'd2) ? u8esc_pkg::MIN_2B
               : (n == 3'd3) ? u8esc_pkg::MIN_3B : u8esc_pkg::MIN_4B;
          if (v >= minv && v < u8esc_pkg::CP_LIMIT
              && !(v >= 21'h00D800 && v <= 21'h00DFFF)
              && !(v >= u8esc_pkg::NONCHAR_LO && v <= u8esc_pkg::NONCHAR_HI)
              && v[15:0] < 16'hFFFE) begin
            op = u8esc_pkg::OP_COPY;
          end else begin
            op = u8esc_pkg::OP_REPL;
          end
        end else if (fin) begin
          op = u8esc_pkg::OP_REPL;
        end
      end
      if (op == u8esc_pkg::OP_NONE) break;
      if (op == u8esc_pkg::OP_COPY) begin
        repeat (n) begin
          step_q.push_back('{held_q[0], 1'b0, 1'b0});
          void'(held_q.pop_front());
        end
      end else begin
        step_q.push_back('{u8esc_pkg::REPL_B0, 1'b0, 1'b0});
        step_q.push_back('{u8esc_pkg::REPL_B1, 1'b0, 1'b0});
        step_q.push_back('{u8esc_pkg::REPL_B2, 1'b0, 1'b0});
        void'(held_q.pop_front());
      end
    end
    if (step_q.size() > 0) begin
      step_q[step_q.size() - 1].run_end = 1'b1;
      step_q[step_q.size() - 1].str_end = fin;
    end
  endfunction

  // Entered and left at a falling edge.
  task automatic drive_item(input logic [7:0] b, input logic fin,
                            input logic [1:0] n_typed, input logic [23:0] typed);
    int gap;
    if ($urandom_range(0, 11) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    escape_step(b, fin);
    if (n_typed == 2'd0) begin
      foreach (step_q[i]) exp_q.push_back(step_q[i]);
    end else begin
      for (int i = 0; i < int'(n_typed); i++) begin
        exp_q.push_back('{typed[8*i +: 8], i == int'(n_typed) - 1,
                          fin && (i == int'(n_typed) - 1)});
      end
    end
    @(negedge clk);
  endtask

  initial begin
    int         stall;
    esc_out_t   want;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 11) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (exp_q.size() == 0) begin
        $error("unexpected result item: out_byte %h", out_tdata);
        n_err++;
      end else begin
        want = exp_q.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_tdata);
          n_err++;
        end
        if (out_tlast !== want.run_end) begin
          $error("run_last: expected %b, got %b", want.run_end, out_tlast);
          n_err++;
        end
        if (out_tuser !== want.str_end) begin
          $error("string_done: expected %b, got %b", want.str_end, out_tuser);
          n_err++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    int          sent;
    int          kind;
    int          n;
    int          pick;
    logic [20:0] cp;
    logic [31:0] word;
    logic [7:0]  seq_q[$];
    logic        str_end;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIR_TAB[r]) begin
      drive_item(DIR_TAB[r].data, DIR_TAB[r].fin, DIR_TAB[r].n_typed, DIR_TAB[r].typed);
    end

    // mostly well-formed sequences, some broken, some noise
    sent = 0;
    while (sent < RAND_ITEMS) begin
      seq_q.delete();
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        seq_q.push_back(8'($urandom_range(1, 255)));
      end else if (kind == 3) begin
        seq_q.push_back(8'h00);
      end else begin
        n = $urandom_range(1, 4);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          cp = CORNER_CP[$urandom_range(0, 18)];
          n = (cp < u8esc_pkg::MIN_2B) ? 1 : (cp < u8esc_pkg::MIN_3B) ? 2
            : (cp < u8esc_pkg::MIN_4B) ? 3 : 4;
        end else if (pick == 1 && n > 1) begin
          cp = 21'($urandom_range(0, int'((n == 2) ? u8esc_pkg::MIN_2B
                                        : (n == 3) ? u8esc_pkg::MIN_3B
                                        : u8esc_pkg::MIN_4B) - 1));
        end else begin
          case (n)
            1: cp = 21'($urandom_range(1, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3: cp = 21'($urandom_range('h800, 'hFFFF));
            default: cp = ($urandom_range(0, 3) == 0) ? 21'($urandom_range('h10000, 'h1FFFFF))
                                                      : 21'($urandom_range('h10000, 'h10FFFF));
          endcase
        end
        case (n)
          1: word = {24'd0, 1'b0, cp[6:0]};
          2: word = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
          3: word = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
          default: word = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                           5'b11110, cp[20:18]};
        endcase
        for (int i = 0; i < n; i++) seq_q.push_back(word[8*i +: 8]);
        if (kind >= 17 && n > 1) begin
          if ($urandom_range(0, 1) == 0) begin
            seq_q = seq_q[0:$urandom_range(0, n - 2)];
          end else begin
            seq_q[$urandom_range(1, n - 1)] = 8'($urandom_range(1, 255));
          end
        end
      end
      str_end = ($urandom_range(0, 5) == 0);
      foreach (seq_q[i]) begin
        drive_item(seq_q[i], str_end && (i == seq_q.size() - 1), 2'd0, 24'h0);
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    while (exp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/u8esc_pkg.sv
hw/rtl/u8esc_ctrl.sv
hw/rtl/u8esc_dp.sv
hw/rtl/utf8_invalid_byte_escaper.sv
bench/tb_top.sv
